// File: design/vgab_pkg.sv
package vgab_pkg;

  localparam int ROW_BITS_DEF = 12;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 32;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_QUAD_HEIGHT  = 2'd0,
    REG_TOP_COLOR    = 2'd1,
    REG_BOTTOM_COLOR = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [ROW_BITS_DEF-1:0] row_index;
    logic [7:0]  dest_red;
    logic [7:0]  dest_green;
    logic [7:0]  dest_blue;
    logic [7:0]  dest_alpha;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } pixel_out_t;

  // Rounded c*a/255 for c, a in 0..255: x = c*a+127 <= 65152,
  // x/255 = (x + (x>>8) + 1) >> 8 holds over that range.
  function automatic logic [7:0] mul_round(input logic [7:0] c, input logic [7:0] a);
    logic [16:0] x;
    logic [16:0] y;
    begin
      x = 17'(c) * 17'(a) + 17'd127;
      y = x + (x >> 8) + 17'd1;
      mul_round = y[15:8];
    end
  endfunction

endpackage

// File: design/vertical_gradient_alpha_blend_unit.sv
// Channel  | Signals                          | Handshake
// ---------+----------------------------------+--------------------------------
// input    | start, busy, pixel_in            | taken when start && !busy
// result   | done, pixel_out                  | one cycle, receiver cannot stall
// config   | cfg_we, cfg_index, cfg_data      | written when cfg_we
//
// One transaction enters per clock; busy is tied low since nothing stalls.
// Pipeline order: clamp, numerator, weighted sums, eight divider
// stages for the interpolation quotient, products, then blend and output.
// The divider has eight stages, one per quotient bit; rate is one per clock.
// Reset (synchronous, rst high) clears valid bits and the config registers.
module vertical_gradient_alpha_blend_unit import vgab_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  pixel_in_t                pixel_in,
  output logic                     done,
  output pixel_out_t               pixel_out,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);
  // den = 2h needs ROW_BITS+1 bits; 255*den + den/2 stays below 256*den.
  localparam int ROW_BITS = ROW_BITS_DEF;
  localparam int DEN_BITS = ROW_BITS + 1;
  localparam int SUM_BITS = DEN_BITS + 8;

  logic [ROW_BITS-1:0] quad_height;
  logic [31:0]         top_color;
  logic [31:0]         bottom_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      quad_height  <= ROW_BITS'(1);
      top_color    <= '0;
      bottom_color <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_QUAD_HEIGHT:  quad_height  <= cfg_data[ROW_BITS-1:0];
        REG_TOP_COLOR:    top_color    <= cfg_data;
        REG_BOTTOM_COLOR: bottom_color <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;
  logic accept;
  assign accept = start && !busy;

  // Stage 1: clamp the row.
  logic [ROW_BITS-1:0] h_eff;
  assign h_eff = (quad_height == '0) ? ROW_BITS'(1) : quad_height;
  logic                s1_v;
  logic [ROW_BITS-1:0] s1_row;
  logic [ROW_BITS-1:0] s1_h;
  logic [31:0]         s1_dst;
  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else     s1_v <= accept;
    s1_row <= (pixel_in.row_index[ROW_BITS-1:0] >= h_eff) ? h_eff - ROW_BITS'(1)
                                                          : pixel_in.row_index[ROW_BITS-1:0];
    s1_h   <= h_eff;
    s1_dst <= {pixel_in.dest_alpha, pixel_in.dest_red, pixel_in.dest_green,
               pixel_in.dest_blue};
  end

  // Stage 2: numerator and weights.
  logic                s2_v;
  logic [DEN_BITS-1:0] s2_num;
  logic [DEN_BITS-1:0] s2_wt;
  logic [DEN_BITS-1:0] s2_den;
  logic [31:0]         s2_dst;
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else     s2_v <= s1_v;
    s2_num <= {s1_row, 1'b1};
    s2_wt  <= {s1_h, 1'b0} - {s1_row, 1'b1};
    s2_den <= {s1_h, 1'b0};
    s2_dst <= s1_dst;
  end

  // Stage 3: per-channel weighted sum plus den/2 (channel order A,R,G,B).
  logic                          s3_v;
  logic [3:0][SUM_BITS-1:0]      s3_sum;
  logic [DEN_BITS-1:0]           s3_den;
  logic [31:0]                   s3_dst;
  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else     s3_v <= s2_v;
    for (int k = 0; k < 4; k++) begin
      s3_sum[k] <= SUM_BITS'(top_color[31-8*k -: 8]) * SUM_BITS'(s2_wt)
                 + SUM_BITS'(bottom_color[31-8*k -: 8]) * SUM_BITS'(s2_num)
                 + SUM_BITS'(s2_den >> 1);
    end
    s3_den <= s2_den;
    s3_dst <= s2_dst;
  end

  // Four divider lanes share one valid bit; the destination pixel rides
  // along as the tag.
  logic [3:0][7:0] src;
  logic            dv_v;
  logic [31:0]     dv_dst;
  vgab_divider #(
    .NUM_BITS(SUM_BITS), .DEN_BITS(DEN_BITS), .Q_BITS(8), .LANES(4), .TAG_BITS(32)
  ) u_div (
    .clk(clk), .rst(rst), .in_valid(s3_v), .in_num(s3_sum),
    .in_den(s3_den), .in_tag(s3_dst), .out_valid(dv_v),
    .out_quo(src), .out_tag(dv_dst)
  );

  // Stage 12: products.
  logic       s4_v;
  logic [7:0] s4_a;
  logic [7:0] s4_src [3];
  logic [7:0] s4_dst [4];
  logic [7:0] s4_ps  [3];
  logic [7:0] s4_pd  [4];
  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else     s4_v <= dv_v;
    s4_a <= src[0];
    for (int k = 0; k < 3; k++) begin
      s4_src[k] <= src[k+1];
      s4_ps[k]  <= mul_round(src[k+1], src[0]);
    end
    for (int k = 0; k < 4; k++) begin
      s4_dst[k] <= dv_dst[31-8*k -: 8];
      s4_pd[k]  <= mul_round(dv_dst[31-8*k -: 8], 8'd255 - src[0]);
    end
  end

  // Stage 13: sums, saturation and the alpha special cases.
  logic [8:0] sum_c [3];
  always_comb begin
    for (int k = 0; k < 3; k++) sum_c[k] = {1'b0, s4_ps[k]} + {1'b0, s4_pd[k+1]};
  end
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= s4_v;
    if (s4_a == 8'd0) begin
      pixel_out <= {s4_dst[1], s4_dst[2], s4_dst[3], s4_dst[0]};
    end else if (s4_a == 8'd255) begin
      pixel_out <= {s4_src[0], s4_src[1], s4_src[2], 8'd255};
    end else begin
      pixel_out.out_red   <= sum_c[0][8] ? 8'd255 : sum_c[0][7:0];
      pixel_out.out_green <= sum_c[1][8] ? 8'd255 : sum_c[1][7:0];
      pixel_out.out_blue  <= sum_c[2][8] ? 8'd255 : sum_c[2][7:0];
      pixel_out.out_alpha <= s4_a + s4_pd[0];
    end
  end
endmodule

// File: design/vgab_divider.sv
module vgab_divider #(
  parameter int NUM_BITS = 21,
  parameter int DEN_BITS = 13,
  parameter int Q_BITS   = 8,
  parameter int LANES    = 4,
  parameter int TAG_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [LANES-1:0][NUM_BITS-1:0] in_num,
  input  logic [DEN_BITS-1:0]            in_den,
  input  logic [TAG_BITS-1:0]            in_tag,
  output logic                           out_valid,
  output logic [LANES-1:0][Q_BITS-1:0]   out_quo,
  output logic [TAG_BITS-1:0]            out_tag
);
  // Pipelined restoring divider, one quotient bit per stage, with several
  // numerators sharing one denominator. NUM_BITS is Q_BITS + DEN_BITS and
  // every numerator stays below den << Q_BITS, so the quotient fits in
  // Q_BITS bits and the remainder always stays below den.
  logic                           vld [1:Q_BITS];
  logic [LANES-1:0][DEN_BITS-1:0] rem [1:Q_BITS];
  logic [LANES-1:0][Q_BITS-1:0]   nm  [1:Q_BITS];
  logic [DEN_BITS-1:0]            dn  [1:Q_BITS];
  logic [LANES-1:0][Q_BITS-1:0]   qt  [1:Q_BITS];
  logic [TAG_BITS-1:0]            tg  [1:Q_BITS];

  for (genvar s = 0; s < Q_BITS; s++) begin : g_st
    logic                           sv;
    logic [LANES-1:0][DEN_BITS-1:0] sr;
    logic [LANES-1:0][Q_BITS-1:0]   sn;
    logic [DEN_BITS-1:0]            sd;
    logic [LANES-1:0][Q_BITS-1:0]   sq;
    logic [TAG_BITS-1:0]            st;
    logic [LANES-1:0][DEN_BITS:0]   trial;

    if (s == 0) begin : g_first
      // The numerator bits above the quotient range form the first remainder.
      always_comb begin
        sv = in_valid;
        sd = in_den;
        st = in_tag;
        sq = '0;
        for (int l = 0; l < LANES; l++) begin
          sr[l] = in_num[l][Q_BITS +: DEN_BITS];
          sn[l] = in_num[l][Q_BITS-1:0];
        end
      end
    end else begin : g_rest
      always_comb begin
        sv = vld[s];
        sr = rem[s];
        sn = nm[s];
        sd = dn[s];
        sq = qt[s];
        st = tg[s];
      end
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) trial[l] = {sr[l], sn[l][Q_BITS-1-s]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= sv;
      end
      nm[s+1] <= sn;
      dn[s+1] <= sd;
      tg[s+1] <= st;
      for (int l = 0; l < LANES; l++) begin
        if (trial[l] >= {1'b0, sd}) begin
          rem[s+1][l] <= DEN_BITS'(trial[l] - {1'b0, sd});
          qt[s+1][l]  <= {sq[l][Q_BITS-2:0], 1'b1};
        end else begin
          rem[s+1][l] <= trial[l][DEN_BITS-1:0];
          qt[s+1][l]  <= {sq[l][Q_BITS-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[Q_BITS];
  assign out_quo   = qt[Q_BITS];
  assign out_tag   = tg[Q_BITS];
endmodule

// File: design/vgab_checker.sv
module vgab_checker import vgab_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done
);
  a_no_busy: assert property (@(posedge clk) busy == 1'b0) else $error("busy high");
  a_done_reset: assert property (@(posedge clk) rst |=> !done) else $error("done after reset");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##13 done) else $error("result missing");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 13)) else $error("spurious result");
endmodule

bind vertical_gradient_alpha_blend_unit vgab_checker u_vgab_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done)
);
